@@ design/assert_macros.svh @@
// assertion helpers shared by the vslw modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property that must hold at every clock edge out of reset
`define VSLW_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("vslw check failed");

// antecedent implies consequent in the same cycle
`define VSLW_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("vslw implication failed");

`else

`define VSLW_ASSERT(lbl, clk, rstn, prop)
`define VSLW_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ design/vslw_pkg.sv @@
package vslw_pkg;

    localparam int VEL_W  = 16;
    localparam int STEP_W = 15;
    localparam int TMO_W  = 16;
    localparam int IDLE_W = 17;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;

    localparam logic [STEP_W-1:0] STEP_RESET = 15'd160;
    localparam logic [TMO_W-1:0]  TMO_RESET  = 16'd0;
    localparam logic [IDLE_W-1:0] IDLE_MAX   = {IDLE_W{1'b1}};

    // register indexes on the config port
    localparam logic [IDX_W-1:0] CFG_MAX_STEP_X  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_MAX_STEP_Y  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_TIMEOUT     = 2'd2;

    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_TICK = 2'd1,
        OP_FREE = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_ENABLE = 2'd1,
        ACT_BRAKE  = 2'd2
    } action_t;

    typedef struct packed {
        logic load_goal;
        logic step_en;
    } lane_ctl_t;

    typedef struct packed {
        logic       active;
        logic [1:0] power_action;
        logic       timed_out;
    } status_t;

    typedef struct packed {
        logic                    active;
        logic signed [VEL_W-1:0] velocity_x;
        logic signed [VEL_W-1:0] velocity_y;
        logic [1:0]              power_action;
        logic                    timed_out;
    } result_t;

endpackage

@@ design/velocity_slew_limiter_watchdog_unit.sv @@
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+---------------------------------------------
// input    | in        | s_valid / s_ready    | s_opcode, s_target_x, s_target_y
// result   | out       | m_valid / m_ready    | m_active, m_velocity_x, m_velocity_y,
//          |           |                      | m_power_action, m_timed_out
// config   | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one beat per cycle while s_ready is high; each result is registered into the m_* queue
// state update (both axis lanes and the watchdog) is done in the accepting cycle
// a two-entry output queue holds results, s_ready drops only when both entries are full
// aresetn is synchronous: config returns to max_step 160/160, timeout 0; state clears to zero
// cfg_ready is always high; a write takes effect at the next cycle

module velocity_slew_limiter_watchdog_unit (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_opcode,
    input  logic signed [vslw_pkg::VEL_W-1:0] s_target_x,
    input  logic signed [vslw_pkg::VEL_W-1:0] s_target_y,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_active,
    output logic signed [vslw_pkg::VEL_W-1:0] m_velocity_x,
    output logic signed [vslw_pkg::VEL_W-1:0] m_velocity_y,
    output logic [1:0]                        m_power_action,
    output logic                              m_timed_out,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vslw_pkg::IDX_W-1:0]        cfg_index,
    input  logic [vslw_pkg::CFG_W-1:0]        cfg_data
);
    import vslw_pkg::*;

    logic                    fire;
    lane_ctl_t               lane_ctl;
    status_t                 status;
    logic [STEP_W-1:0]       max_step_x, max_step_y;
    logic signed [VEL_W-1:0] ramp_x, ramp_y;
    result_t                 out_beat;

    // config writes are always taken
    assign cfg_ready = 1'b1;
    assign fire      = s_valid && s_ready;

    // watchdog, power state and register file
    vslw_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .opcode     (s_opcode),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .lane_ctl   (lane_ctl),
        .max_step_x (max_step_x),
        .max_step_y (max_step_y),
        .status     (status)
    );

    // one slew lane per axis, same control for both
    vslw_lane u_lane_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (lane_ctl),
        .goal_in  (s_target_x),
        .max_step (max_step_x),
        .ramp_out (ramp_x)
    );

    vslw_lane u_lane_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (lane_ctl),
        .goal_in  (s_target_y),
        .max_step (max_step_y),
        .ramp_out (ramp_y)
    );

    // merge lane results with status into the output queue
    vslw_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fire),
        .status    (status),
        .ramp_x    (ramp_x),
        .ramp_y    (ramp_y),
        .room      (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_beat  (out_beat)
    );

    assign m_active       = out_beat.active;
    assign m_velocity_x   = out_beat.velocity_x;
    assign m_velocity_y   = out_beat.velocity_y;
    assign m_power_action = out_beat.power_action;
    assign m_timed_out    = out_beat.timed_out;

endmodule

@@ design/vslw_lane.sv @@
`include "assert_macros.svh"

module vslw_lane (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  vslw_pkg::lane_ctl_t              ctl,
    input  logic signed [vslw_pkg::VEL_W-1:0]  goal_in,
    input  logic [vslw_pkg::STEP_W-1:0]        max_step,
    output logic signed [vslw_pkg::VEL_W-1:0]  ramp_out
);
    import vslw_pkg::*;

    logic signed [VEL_W-1:0] goal_reg, goal_next;
    logic signed [VEL_W-1:0] ramp_reg, ramp_next;
    logic signed [VEL_W-1:0] ramp_step;

    logic signed [VEL_W:0] g17, c17, abs_g, abs_c, diff, lim, dclip, sum;
    logic                  same_sign;

    // one slew step toward the goal: zero when the signs differ, the goal itself when it is no farther from zero
    always_comb begin
        g17   = {goal_reg[VEL_W-1], goal_reg};
        c17   = {ramp_reg[VEL_W-1], ramp_reg};
        abs_g = goal_reg[VEL_W-1] ? -g17 : g17;
        abs_c = ramp_reg[VEL_W-1] ? -c17 : c17;
        lim   = {2'b00, max_step};
        same_sign = (!goal_reg[VEL_W-1] && !ramp_reg[VEL_W-1]) ||
                    ((goal_reg[VEL_W-1] || goal_reg == '0) &&
                     (ramp_reg[VEL_W-1] || ramp_reg == '0));
        diff = g17 - c17;
        if (diff > lim) begin
            dclip = lim;
        end else if (diff < -lim) begin
            dclip = -lim;
        end else begin
            dclip = diff;
        end
        sum = c17 + dclip;
        if (!same_sign) begin
            ramp_step = '0;
        end else if (abs_g <= abs_c) begin
            ramp_step = goal_reg;
        end else begin
            ramp_step = sum[VEL_W-1:0];
        end
    end

    always_comb begin
        goal_next = ctl.load_goal ? goal_in : goal_reg;
        ramp_next = ctl.step_en ? ramp_step : ramp_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_reg <= '0;
            ramp_reg <= '0;
        end else begin
            goal_reg <= goal_next;
            ramp_reg <= ramp_next;
        end
    end

    assign ramp_out = ramp_next;

    // a step never moves past the goal when signs agree
    `VSLW_ASSERT_IMP(a_no_overshoot, aclk, aresetn,
        ctl.step_en && same_sign && !goal_reg[VEL_W-1],
        ramp_step <= goal_reg)
    `VSLW_ASSERT_IMP(a_reverse_zero, aclk, aresetn,
        ctl.step_en && !same_sign, ramp_next == '0)
    `VSLW_ASSERT_IMP(a_hold_idle, aclk, aresetn,
        !ctl.step_en, ramp_next == ramp_reg)

endmodule

@@ design/vslw_ctrl.sv @@
`include "assert_macros.svh"

module vslw_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           fire,
    input  logic [1:0]                     opcode,
    input  logic                           cfg_we,
    input  logic [vslw_pkg::IDX_W-1:0]     cfg_index,
    input  logic [vslw_pkg::CFG_W-1:0]     cfg_data,
    output vslw_pkg::lane_ctl_t            lane_ctl,
    output logic [vslw_pkg::STEP_W-1:0]    max_step_x,
    output logic [vslw_pkg::STEP_W-1:0]    max_step_y,
    output vslw_pkg::status_t              status
);
    import vslw_pkg::*;

    logic [STEP_W-1:0] step_x_reg, step_x_next;
    logic [STEP_W-1:0] step_y_reg, step_y_next;
    logic [TMO_W-1:0]  tmo_reg, tmo_next;
    logic              powered_reg, powered_next;
    logic [IDLE_W-1:0] idle_reg, idle_next, idle_inc;

    always_comb begin
        step_x_next = step_x_reg;
        step_y_next = step_y_reg;
        tmo_next    = tmo_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_MAX_STEP_X: step_x_next = cfg_data[STEP_W-1:0];
                CFG_MAX_STEP_Y: step_y_next = cfg_data[STEP_W-1:0];
                CFG_TIMEOUT:    tmo_next    = cfg_data[TMO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        powered_next        = powered_reg;
        idle_next           = idle_reg;
        idle_inc            = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 1'b1;
        lane_ctl            = '0;
        status.power_action = ACT_NONE;
        status.timed_out    = 1'b0;
        if (fire) begin
            case (opcode)
                OP_SET: begin
                    lane_ctl.load_goal = 1'b1;
                    idle_next          = '0;
                    powered_next       = 1'b1;
                    if (!powered_reg) begin
                        status.power_action = ACT_ENABLE;
                    end
                end
                OP_TICK: begin
                    if (powered_reg) begin
                        idle_next = idle_inc;
                        if (tmo_reg != '0 && idle_inc > {1'b0, tmo_reg}) begin
                            powered_next        = 1'b0;
                            status.power_action = ACT_BRAKE;
                            status.timed_out    = 1'b1;
                        end else begin
                            lane_ctl.step_en = 1'b1;
                        end
                    end
                end
                OP_FREE: begin
                    powered_next        = 1'b0;
                    status.power_action = ACT_BRAKE;
                end
                default: ;
            endcase
        end
        status.active = powered_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_x_reg  <= STEP_RESET;
            step_y_reg  <= STEP_RESET;
            tmo_reg     <= TMO_RESET;
            powered_reg <= 1'b0;
            idle_reg    <= '0;
        end else begin
            step_x_reg  <= step_x_next;
            step_y_reg  <= step_y_next;
            tmo_reg     <= tmo_next;
            powered_reg <= powered_next;
            idle_reg    <= idle_next;
        end
    end

    assign max_step_x = step_x_reg;
    assign max_step_y = step_y_reg;

    `VSLW_ASSERT_IMP(a_tmo_brakes, aclk, aresetn,
        status.timed_out, status.power_action == ACT_BRAKE && !status.active)
    `VSLW_ASSERT(a_ctl_excl, aclk, aresetn,
        !(lane_ctl.load_goal && lane_ctl.step_en))
    `VSLW_ASSERT_IMP(a_power_drop_cause, aclk, aresetn,
        $fell(powered_reg) && $past(aresetn), $past(fire))

endmodule

@@ design/vslw_merge.sv @@
`include "assert_macros.svh"

module vslw_merge (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               push,
    input  vslw_pkg::status_t                  status,
    input  logic signed [vslw_pkg::VEL_W-1:0]  ramp_x,
    input  logic signed [vslw_pkg::VEL_W-1:0]  ramp_y,
    output logic                               room,
    output logic                               out_valid,
    input  logic                               out_ready,
    output vslw_pkg::result_t                  out_beat
);
    import vslw_pkg::*;

    result_t    merged;
    result_t    head_reg, head_next;
    result_t    skid_reg, skid_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    // combine lane velocities with the control flags
    always_comb begin
        merged.active       = status.active;
        merged.velocity_x   = ramp_x;
        merged.velocity_y   = ramp_y;
        merged.power_action = status.power_action;
        merged.timed_out    = status.timed_out;
    end

    assign pop       = (count_reg != 2'd0) && out_ready;
    assign room      = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_beat  = head_reg;

    always_comb begin
        head_next  = head_reg;
        skid_next  = skid_reg;
        count_next = count_reg;
        if (push && !pop) begin
            if (count_reg == 2'd0) begin
                head_next = merged;
            end else begin
                skid_next = merged;
            end
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            head_next  = skid_reg;
            count_next = count_reg - 2'd1;
        end else if (pop && push) begin
            if (count_reg == 2'd1) begin
                head_next = merged;
            end else begin
                head_next = skid_reg;
                skid_next = merged;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    `VSLW_ASSERT(a_count_range, aclk, aresetn, count_reg != 2'd3)
    `VSLW_ASSERT_IMP(a_no_push_full, aclk, aresetn, count_reg == 2'd2, !push)
    `VSLW_ASSERT_IMP(a_push_shows, aclk, aresetn,
        $past(push) && $past(aresetn), out_valid)

endmodule
